// ===== design/assert_macros.svh =====
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under synchronous active-low reset
`define AST_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication under synchronous active-low reset
`define AST_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== design/avr_pkg.sv =====
// types, constants and arithmetic helpers of the axis-angle rotate unit
package avr_pkg;

    typedef enum logic [1:0] {
        CMD_AXIS = 2'd0,
        CMD_X    = 2'd1,
        CMD_Y    = 2'd2,
        CMD_Z    = 2'd3
    } t_cmd;

    localparam int SQ_CELLS  = 32;
    localparam int DIV_CELLS = 31;

    localparam logic signed [33:0] DEG_TO_TURN = 34'sd3054198966;
    localparam logic signed [33:0] RAD_TO_TURN = 34'sd2734261102;
    localparam logic signed [33:0] CORDIC_GAIN_INV = 34'sd652032874;
    localparam logic signed [35:0] Q30_ONE = 36'sd1073741824;
    localparam logic signed [63:0] OPERAND_LIMIT = 64'sd2147483648;
    localparam logic signed [65:0] Q30_HALF = 66'sd536870912;

    localparam logic [31:0] ATAN_TURNS [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
        32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
    };

    typedef struct packed {
        t_cmd               command;
        logic signed [31:0] angle;
        logic signed [31:0] vec_x;
        logic signed [31:0] vec_y;
        logic signed [31:0] vec_z;
        logic signed [31:0] axis_x;
        logic signed [31:0] axis_y;
        logic signed [31:0] axis_z;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic               clipped;
    } t_out_word;

    typedef struct packed {
        logic [63:0] n;
        logic [35:0] rem;
        logic [31:0] root;
    } t_sqrt;

    typedef struct packed {
        logic [61:0] rem;
        logic [31:0] d;
        logic [30:0] q;
    } t_div;

    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [33:0] z;
        logic [1:0]         q;
    } t_cord;

    typedef struct packed {
        t_cmd               cmd;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] az;
    } t_axis_ctx;

    typedef struct packed {
        t_cmd               cmd;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] az;
        logic               len_zero;
        logic               len_one;
    } t_sel_ctx;

    typedef struct packed {
        logic               zero;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] vz;
    } t_vec_ctx;

    typedef struct packed {
        logic signed [34:0] c;
        logic signed [34:0] s;
        logic signed [35:0] t;
    } t_trig;

    // product of two fixed-point operands, each clamped to +-2^31, rounded at bit 30
    function automatic logic signed [35:0] qmul(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
        logic signed [32:0] ca;
        logic signed [32:0] cb;
        logic signed [65:0] p;
        ca = (a > OPERAND_LIMIT) ? OPERAND_LIMIT[32:0] :
             (a < -OPERAND_LIMIT) ? 33'(-OPERAND_LIMIT) : a[32:0];
        cb = (b > OPERAND_LIMIT) ? OPERAND_LIMIT[32:0] :
             (b < -OPERAND_LIMIT) ? 33'(-OPERAND_LIMIT) : b[32:0];
        p = 66'(ca) * 66'(cb);
        return 36'((p + Q30_HALF) >>> 30);
    endfunction

endpackage

// ===== design/avr_in_if.sv =====
// input channel of the rotate unit
interface avr_in_if import avr_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_word data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

// ===== design/avr_out_if.sv =====
// output channel of the rotate unit
interface avr_out_if import avr_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_word data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

// ===== design/avr_delay.sv =====
// enabled shift line that keeps side data aligned with the cell chains
module avr_delay import avr_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [WIDTH-1:0] i_data,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_line [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_line[0] <= i_data;
            for (int k = 1; k < DEPTH; k++) begin
                r_line[k] <= r_line[k-1];
            end
        end
    end

    assign o_data = r_line[DEPTH-1];

endmodule

// ===== design/avr_sqrt_cell.sv =====
// one result bit of the integer square root
module avr_sqrt_cell import avr_pkg::*; #(
    parameter int K = 31
) (
    input  logic  i_clk,
    input  logic  i_en,
    input  t_sqrt i_data,
    output t_sqrt o_data
);

    t_sqrt       r_out;
    t_sqrt       n_out;
    logic [35:0] w_rem;
    logic [35:0] w_trial;

    always_comb begin
        w_rem   = {i_data.rem[33:0], i_data.n[2*K+1 -: 2]};
        w_trial = {2'b00, i_data.root, 2'b01};
        n_out.n = i_data.n;
        if (w_rem >= w_trial) begin
            n_out.rem  = w_rem - w_trial;
            n_out.root = {i_data.root[30:0], 1'b1};
        end else begin
            n_out.rem  = w_rem;
            n_out.root = {i_data.root[30:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= n_out;
        end
    end

    assign o_data = r_out;

endmodule

// ===== design/avr_div_cell.sv =====
// one quotient bit of the restoring divider
module avr_div_cell import avr_pkg::*; #(
    parameter int BIT = 30
) (
    input  logic i_clk,
    input  logic i_en,
    input  t_div i_data,
    output t_div o_data
);

    t_div        r_out;
    t_div        n_out;
    logic [62:0] w_trial;

    always_comb begin
        w_trial = 63'(i_data.d) << BIT;
        n_out   = i_data;
        if ({1'b0, i_data.rem} >= w_trial) begin
            n_out.rem    = i_data.rem - w_trial[61:0];
            n_out.q[BIT] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= n_out;
        end
    end

    assign o_data = r_out;

endmodule

// ===== design/avr_cordic_cell.sv =====
// one micro-rotation of the rotation-mode cordic
module avr_cordic_cell import avr_pkg::*; #(
    parameter int I = 0
) (
    input  logic  i_clk,
    input  logic  i_en,
    input  t_cord i_data,
    output t_cord o_data
);

    localparam logic signed [33:0] ATAN = 34'(ATAN_TURNS[I]);

    t_cord              r_out;
    t_cord              n_out;
    logic signed [33:0] w_dx;
    logic signed [33:0] w_dy;

    always_comb begin
        w_dx    = i_data.y >>> I;
        w_dy    = i_data.x >>> I;
        n_out.q = i_data.q;
        if (!i_data.z[33]) begin
            n_out.x = i_data.x - w_dx;
            n_out.y = i_data.y + w_dy;
            n_out.z = i_data.z - ATAN;
        end else begin
            n_out.x = i_data.x + w_dx;
            n_out.y = i_data.y - w_dy;
            n_out.z = i_data.z + ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= n_out;
        end
    end

    assign o_data = r_out;

endmodule

// ===== design/vector_axis_angle_rotate_unit.sv =====
// top level: axis-angle vector rotation, one word per cycle while o_out does not stall
//
//  channel  | dir | handshake       | word
//  i_in     | in  | valid / ready   | command, angle, vector, axis
//  o_out    | out | valid / ready   | rotated vector, clipped
//
// one word enters per cycle unless o_out stalls; the pipeline length is mostly
// set by the 32 square-root cells and the 31 divider cells in series
// the cordic chain of CORDIC_STAGES cells runs beside them
// reset clears only the valid bits of the pipeline
// a stall on o_out freezes the whole pipeline; i_in.ready follows it
module vector_axis_angle_rotate_unit import avr_pkg::*; #(
    parameter int FRAC_BITS     = 16,
    parameter int CORDIC_STAGES = 24
) (
    input logic      i_clk,
    input logic      i_rst_n,
    avr_in_if.sink   i_in,
    avr_out_if.source o_out
);
    `include "assert_macros.svh"

    localparam int PIPE_DEPTH = 2 + SQ_CELLS + DIV_CELLS + 1 + 5;
    localparam int TRIG_DELAY = SQ_CELLS + DIV_CELLS - CORDIC_STAGES - 1;
    localparam int VEC_DELAY  = PIPE_DEPTH - 4;
    localparam int UW         = 62 - FRAC_BITS;
    localparam int SH_U       = 30 - FRAC_BITS;
    localparam int SH_DEG     = FRAC_BITS + 8;
    localparam int SH_RAD     = FRAC_BITS + 2;
    localparam logic signed [65:0] RND_DEG = 66'sd1 <<< (FRAC_BITS + 7);
    localparam logic signed [65:0] RND_RAD = 66'sd1 <<< (FRAC_BITS + 1);
    localparam logic [31:0] LEN_ONE = 32'(64'd1 << FRAC_BITS);

    logic                  w_en;
    logic [PIPE_DEPTH-1:0] r_vld;
    logic [PIPE_DEPTH-1:0] n_vld;

    // stage 1
    t_cmd               r_cmd1;
    logic               r_zero1;
    logic signed [31:0] r_v1 [3];
    logic signed [31:0] r_a1 [3];
    logic [63:0]        r_sqa1 [3];
    logic signed [65:0] r_prod1;
    logic signed [33:0] w_turn_k;

    // stage 2
    t_cmd               r_cmd2;
    logic               r_zero2;
    logic signed [31:0] r_v2 [3];
    logic signed [31:0] r_a2 [3];
    logic [63:0]        r_sq2;
    logic signed [33:0] r_z2;
    logic [1:0]         r_q2;
    logic signed [65:0] w_phase_full;
    logic [31:0]        w_phase;
    logic [31:0]        w_qsum;
    logic [1:0]         w_q;
    logic [31:0]        w_rest;

    // chains
    t_sqrt     w_sq_pipe [SQ_CELLS+1];
    t_cord     w_cord_pipe [CORDIC_STAGES+1];
    t_div      w_div_pipe [3][DIV_CELLS+1];
    t_axis_ctx w_axis_in;
    t_axis_ctx w_axis_out;
    t_sel_ctx  w_sel_in;
    t_sel_ctx  w_sel_out;
    t_vec_ctx  w_vec_in;
    t_vec_ctx  w_vec_out;
    t_trig     r_trig;
    t_trig     n_trig;
    t_trig     w_trig_out;
    logic signed [31:0] w_a_lane [3];
    logic signed [31:0] w_as_lane [3];

    // select stage
    logic signed [UW-1:0] r_u [3];
    logic signed [UW-1:0] n_u [3];
    t_trig                r_trig_s;

    // matrix stages
    logic signed [35:0] r_p1 [6];
    logic signed [35:0] r_su1 [3];
    logic signed [34:0] r_c1;
    logic signed [35:0] r_t1;
    logic signed [35:0] r_tp2 [6];
    logic signed [35:0] r_su2 [3];
    logic signed [34:0] r_c2;
    logic signed [36:0] r_m3 [3][3];
    logic signed [35:0] r_mv4 [3][3];
    logic signed [31:0] r_v4 [3];
    logic               r_zero4;
    t_out_word          r_out;
    t_out_word          n_out;
    logic signed [37:0] w_sum [3];
    logic [2:0]         w_clip;

    assign w_en        = !r_vld[PIPE_DEPTH-1] || o_out.ready;
    assign i_in.ready  = w_en;
    assign o_out.valid = r_vld[PIPE_DEPTH-1];
    assign o_out.data  = r_out;

    always_comb begin
        n_vld = {r_vld[PIPE_DEPTH-2:0], i_in.valid};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= n_vld;
        end
    end

    // stage 1: squares of the axis and angle to turns product
    assign w_turn_k = (i_in.data.command == CMD_AXIS) ? RAD_TO_TURN : DEG_TO_TURN;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cmd1    <= i_in.data.command;
            r_zero1   <= (i_in.data.angle == 32'sd0);
            r_v1[0]   <= i_in.data.vec_x;
            r_v1[1]   <= i_in.data.vec_y;
            r_v1[2]   <= i_in.data.vec_z;
            r_a1[0]   <= i_in.data.axis_x;
            r_a1[1]   <= i_in.data.axis_y;
            r_a1[2]   <= i_in.data.axis_z;
            r_sqa1[0] <= 64'(64'(i_in.data.axis_x) * 64'(i_in.data.axis_x));
            r_sqa1[1] <= 64'(64'(i_in.data.axis_y) * 64'(i_in.data.axis_y));
            r_sqa1[2] <= 64'(64'(i_in.data.axis_z) * 64'(i_in.data.axis_z));
            r_prod1   <= 66'(i_in.data.angle) * 66'(w_turn_k);
        end
    end

    // stage 2: squared length, phase, quadrant and residual
    always_comb begin
        if (r_cmd1 == CMD_AXIS) begin
            w_phase_full = (r_prod1 + RND_RAD) >>> SH_RAD;
        end else begin
            w_phase_full = (r_prod1 + RND_DEG) >>> SH_DEG;
        end
        w_phase = w_phase_full[31:0];
        w_qsum  = w_phase + 32'h2000_0000;
        w_q     = w_qsum[31:30];
        w_rest  = w_phase - {w_q, 30'b0};
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cmd2  <= r_cmd1;
            r_zero2 <= r_zero1;
            r_v2    <= r_v1;
            r_a2    <= r_a1;
            r_sq2   <= r_sqa1[0] + r_sqa1[1] + r_sqa1[2];
            r_z2    <= 34'(signed'(w_rest));
            r_q2    <= w_q;
        end
    end

    // square root chain
    assign w_sq_pipe[0] = '{n: r_sq2, rem: '0, root: '0};

    for (genvar k = 0; k < SQ_CELLS; k++) begin : g_sqrt
        avr_sqrt_cell #(.K(SQ_CELLS - 1 - k)) u_cell (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_data(w_sq_pipe[k]),
            .o_data(w_sq_pipe[k+1])
        );
    end

    assign w_axis_in = '{cmd: r_cmd2, ax: r_a2[0], ay: r_a2[1], az: r_a2[2]};

    avr_delay #(.WIDTH($bits(t_axis_ctx)), .DEPTH(SQ_CELLS)) u_axis_dly (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_data(w_axis_in),
        .o_data(w_axis_out)
    );

    // divider lanes
    assign w_a_lane[0] = w_axis_out.ax;
    assign w_a_lane[1] = w_axis_out.ay;
    assign w_a_lane[2] = w_axis_out.az;

    for (genvar l = 0; l < 3; l++) begin : g_lane
        logic [31:0] w_mag;
        assign w_mag = w_a_lane[l][31] ? 32'(-33'(w_a_lane[l])) : w_a_lane[l];
        assign w_div_pipe[l][0] = '{rem: {w_mag, 30'b0},
                                    d: w_sq_pipe[SQ_CELLS].root, q: '0};
        for (genvar j = 0; j < DIV_CELLS; j++) begin : g_div
            avr_div_cell #(.BIT(DIV_CELLS - 1 - j)) u_cell (
                .i_clk (i_clk),
                .i_en  (w_en),
                .i_data(w_div_pipe[l][j]),
                .o_data(w_div_pipe[l][j+1])
            );
        end
    end

    assign w_sel_in = '{cmd: w_axis_out.cmd, ax: w_axis_out.ax, ay: w_axis_out.ay,
                        az: w_axis_out.az,
                        len_zero: (w_sq_pipe[SQ_CELLS].root == 32'd0),
                        len_one: (w_sq_pipe[SQ_CELLS].root == LEN_ONE)};

    avr_delay #(.WIDTH($bits(t_sel_ctx)), .DEPTH(DIV_CELLS)) u_sel_dly (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_data(w_sel_in),
        .o_data(w_sel_out)
    );

    // cordic chain
    assign w_cord_pipe[0] = '{x: CORDIC_GAIN_INV, y: '0, z: r_z2, q: r_q2};

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
        avr_cordic_cell #(.I(i)) u_cell (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_data(w_cord_pipe[i]),
            .o_data(w_cord_pipe[i+1])
        );
    end

    always_comb begin
        case (w_cord_pipe[CORDIC_STAGES].q)
            2'd0: begin
                n_trig.c = 35'(w_cord_pipe[CORDIC_STAGES].x);
                n_trig.s = 35'(w_cord_pipe[CORDIC_STAGES].y);
            end
            2'd1: begin
                n_trig.c = -35'(w_cord_pipe[CORDIC_STAGES].y);
                n_trig.s = 35'(w_cord_pipe[CORDIC_STAGES].x);
            end
            2'd2: begin
                n_trig.c = -35'(w_cord_pipe[CORDIC_STAGES].x);
                n_trig.s = -35'(w_cord_pipe[CORDIC_STAGES].y);
            end
            default: begin
                n_trig.c = 35'(w_cord_pipe[CORDIC_STAGES].y);
                n_trig.s = -35'(w_cord_pipe[CORDIC_STAGES].x);
            end
        endcase
        n_trig.t = Q30_ONE - 36'(n_trig.c);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_trig <= n_trig;
        end
    end

    avr_delay #(.WIDTH($bits(t_trig)), .DEPTH(TRIG_DELAY)) u_trig_dly (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_data(r_trig),
        .o_data(w_trig_out)
    );

    // unit axis select
    assign w_as_lane[0] = w_sel_out.ax;
    assign w_as_lane[1] = w_sel_out.ay;
    assign w_as_lane[2] = w_sel_out.az;

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            if (w_sel_out.len_zero || w_sel_out.len_one) begin
                n_u[l] = UW'(w_as_lane[l]) <<< SH_U;
            end else if (w_as_lane[l][31]) begin
                n_u[l] = -UW'(signed'({1'b0, w_div_pipe[l][DIV_CELLS].q}));
            end else begin
                n_u[l] = UW'(signed'({1'b0, w_div_pipe[l][DIV_CELLS].q}));
            end
        end
        if (w_sel_out.cmd != CMD_AXIS) begin
            n_u[0] = (w_sel_out.cmd == CMD_X) ? UW'(Q30_ONE) : '0;
            n_u[1] = (w_sel_out.cmd == CMD_Y) ? UW'(Q30_ONE) : '0;
            n_u[2] = (w_sel_out.cmd == CMD_Z) ? UW'(Q30_ONE) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_u      <= n_u;
            r_trig_s <= w_trig_out;
        end
    end

    // matrix: axis products, then scaled by 1 - cos, then assembled
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p1[0]  <= qmul(64'(r_u[0]), 64'(r_u[0]));
            r_p1[1]  <= qmul(64'(r_u[1]), 64'(r_u[1]));
            r_p1[2]  <= qmul(64'(r_u[2]), 64'(r_u[2]));
            r_p1[3]  <= qmul(64'(r_u[0]), 64'(r_u[1]));
            r_p1[4]  <= qmul(64'(r_u[0]), 64'(r_u[2]));
            r_p1[5]  <= qmul(64'(r_u[1]), 64'(r_u[2]));
            r_su1[0] <= qmul(64'(r_u[0]), 64'(r_trig_s.s));
            r_su1[1] <= qmul(64'(r_u[1]), 64'(r_trig_s.s));
            r_su1[2] <= qmul(64'(r_u[2]), 64'(r_trig_s.s));
            r_c1     <= r_trig_s.c;
            r_t1     <= r_trig_s.t;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 6; k++) begin
                r_tp2[k] <= qmul(64'(r_t1), 64'(r_p1[k]));
            end
            r_su2 <= r_su1;
            r_c2  <= r_c1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m3[0][0] <= 37'(r_c2) + 37'(r_tp2[0]);
            r_m3[0][1] <= 37'(r_tp2[3]) - 37'(r_su2[2]);
            r_m3[0][2] <= 37'(r_tp2[4]) + 37'(r_su2[1]);
            r_m3[1][0] <= 37'(r_tp2[3]) + 37'(r_su2[2]);
            r_m3[1][1] <= 37'(r_c2) + 37'(r_tp2[1]);
            r_m3[1][2] <= 37'(r_tp2[5]) - 37'(r_su2[0]);
            r_m3[2][0] <= 37'(r_tp2[4]) - 37'(r_su2[1]);
            r_m3[2][1] <= 37'(r_tp2[5]) + 37'(r_su2[0]);
            r_m3[2][2] <= 37'(r_c2) + 37'(r_tp2[2]);
        end
    end

    // vector and bypass flag
    assign w_vec_in = '{zero: r_zero2, vx: r_v2[0], vy: r_v2[1], vz: r_v2[2]};

    avr_delay #(.WIDTH($bits(t_vec_ctx)), .DEPTH(VEC_DELAY)) u_vec_dly (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_data(w_vec_in),
        .o_data(w_vec_out)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int r = 0; r < 3; r++) begin
                r_mv4[r][0] <= qmul(64'(r_m3[r][0]), 64'(w_vec_out.vx));
                r_mv4[r][1] <= qmul(64'(r_m3[r][1]), 64'(w_vec_out.vy));
                r_mv4[r][2] <= qmul(64'(r_m3[r][2]), 64'(w_vec_out.vz));
            end
            r_v4[0] <= w_vec_out.vx;
            r_v4[1] <= w_vec_out.vy;
            r_v4[2] <= w_vec_out.vz;
            r_zero4 <= w_vec_out.zero;
        end
    end

    // row sums, saturation and zero-angle bypass
    always_comb begin
        logic signed [31:0] sat [3];
        for (int r = 0; r < 3; r++) begin
            w_sum[r] = 38'(r_mv4[r][0]) + 38'(r_mv4[r][1]) + 38'(r_mv4[r][2]);
            if (w_sum[r] > 38'sd2147483647) begin
                sat[r]    = 32'sh7fff_ffff;
                w_clip[r] = 1'b1;
            end else if (w_sum[r] < -38'sd2147483648) begin
                sat[r]    = 32'sh8000_0000;
                w_clip[r] = 1'b1;
            end else begin
                sat[r]    = w_sum[r][31:0];
                w_clip[r] = 1'b0;
            end
        end
        if (r_zero4) begin
            n_out = '{out_x: r_v4[0], out_y: r_v4[1], out_z: r_v4[2], clipped: 1'b0};
        end else begin
            n_out = '{out_x: sat[0], out_y: sat[1], out_z: sat[2], clipped: |w_clip};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

    `AST_NEXT(a_stall_holds, i_clk, i_rst_n, !w_en, r_vld == $past(r_vld))
    `AST_NEXT(a_accept_enters, i_clk, i_rst_n, i_in.valid && i_in.ready, r_vld[0])
    `AST_NEXT(a_last_reaches_out, i_clk, i_rst_n, r_vld[PIPE_DEPTH-2] && w_en, o_out.valid)

endmodule

// ===== tb/sv/vector_axis_angle_rotate_unit_tb.sv =====
// testbench for the axis-angle rotate unit: directed table and random words checked by a predictor
`timescale 1ns / 100ps

module vector_axis_angle_rotate_unit_tb;
    import avr_pkg::*;

    logic i_clk;
    logic i_rst_n;

    avr_in_if  in_ch();
    avr_out_if out_ch();

    vector_axis_angle_rotate_unit dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    localparam int FRAC = 16;
    localparam int STAGES = 24;
    localparam int LATENCY = 71;
    localparam int N_RANDOM = 1530;
    localparam int N_DIRECTED = 20;

    typedef struct {
        t_in_word  w;
        bit        known;
        t_out_word res;
    } t_row;

    t_out_word rotated_q[$];
    int        n_errors;
    int        n_sent;
    bit        sending_done;
    bit        hold_off;
    t_row      rows[N_DIRECTED];

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("vector_axis_angle_rotate_unit_tb: errors");
        $finish;
    end

    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint fx_mul(longint a, longint b);
        longint lim;
        lim = 64'sd1 << 31;
        if (a > lim) a = lim;
        if (a < -lim) a = -lim;
        if (b > lim) b = lim;
        if (b < -lim) b = -lim;
        return shr_floor(a * b + (64'sd1 << 29), 30);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic t_out_word rotate_vector(t_in_word w);
        t_out_word o;
        longint v[3], a[3], u[3], m[3][3];
        longint c, s, t, prod, x, y, z, dx, dy, sum;
        longint unsigned sq, len;
        logic [31:0] phase, rest;
        logic [1:0] q;
        v[0] = w.vec_x; v[1] = w.vec_y; v[2] = w.vec_z;
        a[0] = w.axis_x; a[1] = w.axis_y; a[2] = w.axis_z;
        o.clipped = 1'b0;
        if (w.angle == 0) begin
            o.out_x = w.vec_x; o.out_y = w.vec_y; o.out_z = w.vec_z;
            return o;
        end
        if (w.command == CMD_AXIS) begin
            sq = 0;
            for (int i = 0; i < 3; i++) sq += longint'(a[i] * a[i]);
            len = int_sqrt(sq);
            for (int i = 0; i < 3; i++)
                if (len == 0 || len == (64'd1 << FRAC)) u[i] = a[i] * (64'sd1 << (30 - FRAC));
                else u[i] = (a[i] * (64'sd1 << 30)) / longint'(len);
            prod = longint'(w.angle) * 64'sd2734261102 + (64'sd1 << (FRAC + 1));
            phase = 32'(shr_floor(prod, FRAC + 2));
        end else begin
            for (int i = 0; i < 3; i++) u[i] = (i + 1 == int'(w.command)) ? (64'sd1 << 30) : 0;
            prod = longint'(w.angle) * 64'sd3054198966 + (64'sd1 << (FRAC + 7));
            phase = 32'(shr_floor(prod, FRAC + 8));
        end
        q = 2'((phase + 32'h2000_0000) >> 30);
        rest = phase - {q, 30'd0};
        z = longint'(signed'(rest));
        x = 652032874;
        y = 0;
        for (int i = 0; i < STAGES; i++) begin
            dx = y >>> i; dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(ATAN_TURNS[i]);
            end else begin
                x += dx; y -= dy; z += longint'(ATAN_TURNS[i]);
            end
        end
        case (q)
            2'd0: begin c = x; s = y; end
            2'd1: begin c = -y; s = x; end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
        t = (64'sd1 << 30) - c;
        m[0][0] = c + fx_mul(t, fx_mul(u[0], u[0]));
        m[0][1] = fx_mul(t, fx_mul(u[0], u[1])) - fx_mul(u[2], s);
        m[0][2] = fx_mul(t, fx_mul(u[0], u[2])) + fx_mul(u[1], s);
        m[1][0] = fx_mul(t, fx_mul(u[0], u[1])) + fx_mul(u[2], s);
        m[1][1] = c + fx_mul(t, fx_mul(u[1], u[1]));
        m[1][2] = fx_mul(t, fx_mul(u[1], u[2])) - fx_mul(u[0], s);
        m[2][0] = fx_mul(t, fx_mul(u[0], u[2])) - fx_mul(u[1], s);
        m[2][1] = fx_mul(t, fx_mul(u[1], u[2])) + fx_mul(u[0], s);
        m[2][2] = c + fx_mul(t, fx_mul(u[2], u[2]));
        for (int i = 0; i < 3; i++) begin
            sum = 0;
            for (int j = 0; j < 3; j++) sum += fx_mul(m[i][j], v[j]);
            if (sum > 64'sd2147483647) begin
                sum = 64'sd2147483647; o.clipped = 1'b1;
            end else if (sum < -64'sd2147483648) begin
                sum = -64'sd2147483648; o.clipped = 1'b1;
            end
            case (i)
                0: o.out_x = 32'(sum);
                1: o.out_y = 32'(sum);
                default: o.out_z = 32'(sum);
            endcase
        end
        return o;
    endfunction

    function automatic t_in_word mk(t_cmd c, int ang, int vx, int vy, int vz,
                                    int ax, int ay, int az);
        t_in_word w;
        w.command = c; w.angle = ang;
        w.vec_x = vx; w.vec_y = vy; w.vec_z = vz;
        w.axis_x = ax; w.axis_y = ay; w.axis_z = az;
        return w;
    endfunction

    function automatic t_out_word res(int x, int y, int z, bit clip);
        t_out_word o;
        o.out_x = x; o.out_y = y; o.out_z = z; o.clipped = clip;
        return o;
    endfunction

    function automatic int rnd_q16();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
            2: return int'($urandom_range(0, 20)) - 10;
            default: return int'($urandom_range(0, 32'h01ff_ffff)) - 32'sh0100_0000;
        endcase
    endfunction

    function automatic t_in_word rnd_word();
        t_in_word w;
        w.command = t_cmd'($urandom_range(0, 3));
        case ($urandom_range(0, 9))
            0: w.angle = 0;
            1: w.angle = $urandom;
            default: w.angle = int'($urandom_range(0, 32'h0300_0000)) - 32'sh0180_0000;
        endcase
        w.vec_x = rnd_q16(); w.vec_y = rnd_q16(); w.vec_z = rnd_q16();
        if ($urandom_range(0, 9) == 0) begin
            w.axis_x = 0; w.axis_y = 0; w.axis_z = 0;
        end else if ($urandom_range(0, 9) == 0) begin
            w.axis_x = 0; w.axis_y = 0; w.axis_z = $urandom_range(0, 1) ? 65536 : -65536;
        end else begin
            w.axis_x = rnd_q16(); w.axis_y = rnd_q16(); w.axis_z = rnd_q16();
        end
        return w;
    endfunction

    initial begin
        rows[0]  = '{mk(CMD_X, 0, 32'sh7fff_ffff, 32'sh8000_0000, 5, 1, 2, 3), 1,
                     res(32'sh7fff_ffff, 32'sh8000_0000, 5, 0)};
        rows[1]  = '{mk(CMD_AXIS, 0, -1, 0, 1, 0, 0, 0), 1, res(-1, 0, 1, 0)};
        rows[2]  = '{mk(CMD_X, 90 << 16, 65536, 65536, 0, 0, 0, 0), 0, '0};
        rows[3]  = '{mk(CMD_Y, 90 << 16, 65536, 0, 65536, 0, 0, 0), 0, '0};
        rows[4]  = '{mk(CMD_Z, 90 << 16, 65536, 0, 0, 0, 0, 0), 0, '0};
        rows[5]  = '{mk(CMD_Z, 180 << 16, 65536, -65536, 3, 0, 0, 0), 0, '0};
        rows[6]  = '{mk(CMD_Z, -(45 << 16), 32'sh7fff_ffff, 32'sh7fff_ffff, 0, 0, 0, 0), 0, '0};
        rows[7]  = '{mk(CMD_X, 32'sh7fff_ffff, 1, 2, 3, 0, 0, 0), 0, '0};
        rows[8]  = '{mk(CMD_Y, 32'sh8000_0000, 1, 2, 3, 0, 0, 0), 0, '0};
        rows[9]  = '{mk(CMD_AXIS, 102944, 65536, 0, 0, 0, 0, 0), 0, '0};
        rows[10] = '{mk(CMD_AXIS, 102944, 65536, 0, 0, 0, 0, 65536), 0, '0};
        rows[11] = '{mk(CMD_AXIS, 102944, 65536, 65536, 0, 1, 1, 1), 0, '0};
        rows[12] = '{mk(CMD_AXIS, 205887, 65536, 2, 3, 32'sh7fff_ffff, 32'sh7fff_ffff,
                        32'sh7fff_ffff), 0, '0};
        rows[13] = '{mk(CMD_AXIS, 1, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                        32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000), 0, '0};
        rows[14] = '{mk(CMD_AXIS, 32'sh7fff_ffff, 5, 6, 7, 3, -4, 12), 0, '0};
        rows[15] = '{mk(CMD_AXIS, 32'sh8000_0000, 5, 6, 7, -3, 4, -12), 0, '0};
        rows[16] = '{mk(CMD_Z, 45 << 16, 32'sh7fff_ffff, 32'sh7fff_ffff, 1, 0, 0, 0), 0, '0};
        rows[17] = '{mk(CMD_X, -1, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                        0, 0, 0), 0, '0};
        rows[18] = '{mk(CMD_Y, 270 << 16, -65536, 7, 65536, -1, -1, -1), 0, '0};
        rows[19] = '{mk(CMD_AXIS, -102944, 9, 8, 7, 0, -65536, 0), 0, '0};
    end

    task automatic send_word(t_in_word w, bit known, t_out_word r);
        in_ch.valid <= 1'b1;
        in_ch.data  <= w;
        do @(posedge i_clk); while (!in_ch.ready);
        rotated_q.push_back(known ? r : rotate_vector(w));
        n_sent++;
        @(negedge i_clk);
        if ($urandom_range(0, 2) == 0 && !(n_sent > 400 && n_sent < 600)) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(0, 9) == 0 ? $urandom_range(5, 30) : $urandom_range(1, 3))
                @(negedge i_clk);
        end
    endtask

    initial begin
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;
        i_rst_n      = 1'b0;
        n_errors     = 0;
        n_sent       = 0;
        sending_done = 0;
        hold_off     = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        foreach (rows[k]) send_word(rows[k].w, rows[k].known, rows[k].res);
        repeat (N_RANDOM) send_word(rnd_word(), 0, '0);
        in_ch.valid <= 1'b0;
        sending_done = 1;
    end

    // receiver: random stalls, one long hold-off while the sender keeps going
    initial begin
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (n_sent >= 450 && !hold_off) begin
                hold_off = 1;
                out_ch.ready <= 1'b0;
                repeat (200) @(negedge i_clk);
            end
            if ($urandom_range(0, 3) == 0 && !(n_sent > 900 && n_sent < 1100)) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(0, 9) == 0 ? $urandom_range(5, 40) : $urandom_range(1, 3))
                    @(negedge i_clk);
            end
            out_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (rotated_q.size() == 0) begin
                n_errors++;
                if (n_errors <= 10) $display("unexpected word %h", out_ch.data);
            end else begin
                t_out_word e;
                e = rotated_q.pop_front();
                if (e.out_x !== out_ch.data.out_x || e.out_y !== out_ch.data.out_y ||
                    e.out_z !== out_ch.data.out_z || e.clipped !== out_ch.data.clipped) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("mismatch: expected %0d %0d %0d %0b, got %0d %0d %0d %0b",
                                 e.out_x, e.out_y, e.out_z, e.clipped, out_ch.data.out_x,
                                 out_ch.data.out_y, out_ch.data.out_z, out_ch.data.clipped);
                end
            end
        end
    end

    initial begin
        wait (sending_done);
        while (rotated_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 20) @(posedge i_clk);
        if (n_errors == 0 && rotated_q.size() == 0) begin
            $display("vector_axis_angle_rotate_unit_tb: clean");
        end else begin
            $display("vector_axis_angle_rotate_unit_tb: errors");
        end
        $finish;
    end

endmodule
